// ===== rtl/ldch_pkg.sv =====
// Shared constants, item types and the bin edge table of the depth coverage histogram.
`default_nettype none

package ldch_pkg;

    localparam int STEPS_PER_OCTAVE = 4;
    localparam int LOG2_W_LOW      = -4;
    localparam int LOG2_W_HIGH     = 12;
    localparam int BIN_COUNT       = 64;

    localparam int NBUCKET  = BIN_COUNT + 3;
    localparam int ADDR_W   = $clog2(NBUCKET);
    localparam int BIN_W    = $clog2(BIN_COUNT + 1);
    localparam int CENSUS_N = 7;
    localparam int CENSUS_W = $clog2(CENSUS_N);

    localparam logic [ADDR_W-1:0] BKT_NEAR = ADDR_W'(BIN_COUNT);
    localparam logic [ADDR_W-1:0] BKT_FAR  = ADDR_W'(BIN_COUNT + 1);
    localparam logic [ADDR_W-1:0] BKT_INV  = ADDR_W'(BIN_COUNT + 2);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READB = 2'd1;
    localparam logic [1:0] REQ_READC = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [2:0] CLS_DISPLACED = 3'd0;
    localparam logic [2:0] CLS_LAST      = 3'd5;
    localparam logic [CENSUS_W-1:0] CEN_WIDE = CENSUS_W'(6);
    localparam logic [6:0] CEN_TOTAL = 7'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         draw_class;
        logic signed [31:0] area;
        logic [31:0]        q_low;
        logic [31:0]        q_high;
        logic               q_invalid;
        logic [31:0]        prim_count;
        logic [31:0]        vert_count;
        logic [6:0]         read_index;
    } req_item_t;

    typedef struct packed {
        logic [47:0] coverage_sum;
        logic [63:0] moment_sum;
        logic [47:0] prim_sum;
        logic [47:0] vert_sum;
        logic [47:0] census_count;
    } result_t;

    typedef struct packed {
        logic [47:0] cov;
        logic [63:0] mom;
        logic [47:0] prim;
        logic [47:0] vert;
    } bucket_t;

    localparam int BKT_W = $bits(bucket_t);

    typedef logic [63:0] edge_arr_t [0:BIN_COUNT];

    // True when m to the power STEPS_PER_OCTAVE, in Q1.31, stays at or below 2^r.
    function automatic logic pow_le(logic [63:0] m, int r);
        logic [63:0] mant;
        int ex;
        mant = 64'h8000_0000;
        ex = 0;
        for (int k = 0; k < STEPS_PER_OCTAVE; k++)
        begin
            mant = (mant * m) >> 31;
            if (mant >= 64'h1_0000_0000)
            begin
                mant = mant >> 1;
                ex++;
            end
        end
        return (ex < r) || ((ex == r) && (mant <= 64'h8000_0000));
    endfunction

    function automatic edge_arr_t build_edges();
        edge_arr_t   e;
        logic [63:0] roots [STEPS_PER_OCTAVE];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        int n;
        int qq;
        int rr;
        int sh;
        for (int r = 0; r < STEPS_PER_OCTAVE; r++)
        begin
            lo = 64'h8000_0000;
            hi = 64'hFFFF_FFFF;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow_le(mid, r))
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            roots[r] = lo;
        end
        for (int i = 0; i <= BIN_COUNT; i++)
        begin
            n = (-LOG2_W_LOW) * STEPS_PER_OCTAVE - i;
            if (n >= 0)
                qq = n / STEPS_PER_OCTAVE;
            else
                qq = -((-n + STEPS_PER_OCTAVE - 1) / STEPS_PER_OCTAVE);
            rr = n - qq * STEPS_PER_OCTAVE;
            sh = qq - 7;
            if (sh >= 0)
                e[i] = roots[rr] << sh;
            else if (-sh < 64)
                e[i] = roots[rr] >> (-sh);
            else
                e[i] = 64'd0;
        end
        return e;
    endfunction

    localparam edge_arr_t EDGE_ROM = build_edges();
    localparam logic [63:0] NEAR_EDGE = EDGE_ROM[0];
    localparam logic [63:0] FAR_EDGE  = (64'd1 << 24) >> LOG2_W_HIGH;

endpackage

`default_nettype wire

// ===== rtl/ldch_ram.sv =====
// Generic single write port RAM with a registered read port.
`default_nettype none

module ldch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ldch_div.sv =====
// Restoring divider, one quotient bit per cycle, for a quotient known to fit 32 bits.
`default_nettype none

module ldch_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        run_reg;
    logic        run_next;
    logic        done_reg;
    logic        done_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] low_reg;
    logic [31:0] low_next;
    logic [31:0] dsr_reg;
    logic [31:0] dsr_next;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, low_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            // The upper half is already below the divisor, so only 32 steps remain.
            run_next = 1'b1;
            cnt_next = 5'd31;
            rem_next = dividend[63:32];
            low_next = dividend[31:0];
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                low_next = {low_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                low_next = {low_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

// ===== rtl/log_depth_coverage_histogram_top.sv =====
// Top level of the logarithmic depth coverage histogram: sequencer, shared datapath, stores.
//
// An item is taken when start is high and busy is low, and busy stays high until the item
// is done. Reads answer with one result_valid pulse: a bucket read after a RAM read state,
// a census read straight from decode, the total after summing the class counters one by
// one; the result cannot be stalled. A clear or an add of a non-displaced class ends in
// the decode state. A valid displaced draw with one q walks the edges to find its bucket,
// then does a multiply and a read-modify-write. A draw with a q range spends, for each
// bucket it overlaps, a multiply, the 32-step shared divider, another multiply and a
// read-modify-write, skips missed bins and ends with a bucket search for the midpoint.
`default_nettype none

module log_depth_coverage_histogram_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ldch_pkg::req_item_t item,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data,
    output logic                    result_valid,
    output ldch_pkg::result_t       result
);

    import ldch_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_RDOUT  = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_SLICE  = 4'd6;
    localparam logic [3:0] S_PREP   = 4'd7;
    localparam logic [3:0] S_MUL1   = 4'd8;
    localparam logic [3:0] S_DIVGO  = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_MUL2   = 4'd11;
    localparam logic [3:0] S_MULQ   = 4'd12;
    localparam logic [3:0] S_RMW_RD = 4'd13;
    localparam logic [3:0] S_RMW_WR = 4'd14;
    localparam logic [3:0] S_NEXT   = 4'd15;

    localparam logic [2:0] PH_INV    = 3'd0;
    localparam logic [2:0] PH_SINGLE = 3'd1;
    localparam logic [2:0] PH_FAR    = 3'd2;
    localparam logic [2:0] PH_NEAR   = 3'd3;
    localparam logic [2:0] PH_BINS   = 3'd4;
    localparam logic [2:0] PH_MID    = 3'd5;

    function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [63:0] sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    logic [31:0]         q_ovf_reg, q_ovf_next;
    logic [NBUCKET-1:0]  vld_reg, vld_next;
    logic [47:0]         census_reg [CENSUS_N];
    logic [47:0]         census_next [CENSUS_N];
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic [1:0]          req_reg, req_next;
    logic [2:0]          cls_reg, cls_next;
    logic [6:0]          idx_reg, idx_next;
    logic [31:0]         area_reg, area_next;
    logic [31:0]         qmin_reg, qmin_next;
    logic [31:0]         qmax_reg, qmax_next;
    logic                qinv_reg, qinv_next;
    logic [31:0]         prim_reg, prim_next;
    logic [31:0]         vert_reg, vert_next;
    logic [31:0]         lo_reg, lo_next;
    logic [31:0]         hi_reg, hi_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BIN_W-1:0]    scan_i_reg, scan_i_next;
    logic [31:0]         scan_q_reg, scan_q_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [31:0]         qa_reg, qa_next;
    logic [31:0]         qb_reg, qb_next;
    logic [31:0]         dlt_reg, dlt_next;
    logic [31:0]         mid_reg, mid_next;
    logic [63:0]         prod_reg, prod_next;
    logic [31:0]         part_reg, part_next;
    logic [47:0]         sum_reg, sum_next;
    logic [CENSUS_W-1:0] k_reg, k_next;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         sa;
    logic [63:0]         sb;
    logic [ADDR_W-1:0]   slice_addr;
    logic [63:0]         e_hi;
    logic [63:0]         e_lo;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [BKT_W-1:0]    ram_wdata;
    logic [BKT_W-1:0]    ram_rdata;
    bucket_t             cur;
    bucket_t             upd;
    logic [31:0]         add_cov;
    logic [63:0]         add_mom;
    logic [31:0]         add_pr;
    logic [31:0]         add_ve;
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;
    logic                is_inv;

    ldch_ram #(
        .WIDTH(BKT_W),
        .DEPTH(NBUCKET)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ldch_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(prod_reg),
        .divisor (qmax_reg - qmin_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    assign ram_raddr = (state_reg == S_DECODE) ? idx_reg[ADDR_W-1:0] : addr_reg;
    assign div_start = (state_reg == S_DIVGO);
    assign ram_we    = (state_reg == S_RMW_WR);

    // Shared multiplier operands.
    assign mul_a = (state_reg == S_MUL2) ? part_reg : area_reg;
    always_comb
    begin
        case (state_reg)
            S_MUL1:  mul_b = dlt_reg;
            S_MUL2:  mul_b = mid_reg;
            default: mul_b = qmin_reg;
        endcase
    end

    // Slice bounds of the current phase.
    assign e_hi = EDGE_ROM[bin_reg];
    assign e_lo = EDGE_ROM[BIN_W'(bin_reg + 1'b1)];
    always_comb
    begin
        case (phase_reg)
            PH_FAR:
            begin
                sa = {32'd0, qmin_reg};
                sb = ({32'd0, qmax_reg} < FAR_EDGE) ? {32'd0, qmax_reg} : FAR_EDGE;
                slice_addr = BKT_FAR;
            end
            PH_NEAR:
            begin
                sa = ({32'd0, qmin_reg} > NEAR_EDGE) ? {32'd0, qmin_reg} : NEAR_EDGE;
                sb = {32'd0, qmax_reg};
                slice_addr = BKT_NEAR;
            end
            default:
            begin
                sa = (e_lo > {32'd0, lo_reg}) ? e_lo : {32'd0, lo_reg};
                sb = (e_hi < {32'd0, hi_reg}) ? e_hi : {32'd0, hi_reg};
                slice_addr = ADDR_W'(bin_reg);
            end
        endcase
    end

    // Read-modify-write operands; an entry never written since clear reads as zero.
    assign cur = vld_reg[addr_reg] ? bucket_t'(ram_rdata) : '0;
    always_comb
    begin
        case (phase_reg)
            PH_INV:
            begin
                add_cov = area_reg;
                add_mom = 64'd0;
                add_pr  = prim_reg;
                add_ve  = vert_reg;
            end
            PH_SINGLE:
            begin
                add_cov = area_reg;
                add_mom = prod_reg;
                add_pr  = prim_reg;
                add_ve  = vert_reg;
            end
            PH_MID:
            begin
                add_cov = 32'd0;
                add_mom = 64'd0;
                add_pr  = prim_reg;
                add_ve  = vert_reg;
            end
            default:
            begin
                add_cov = part_reg;
                add_mom = prod_reg;
                add_pr  = 32'd0;
                add_ve  = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        upd.cov  = sat48(cur.cov, {16'd0, add_cov});
        upd.mom  = sat64(cur.mom, add_mom);
        upd.prim = sat48(cur.prim, {16'd0, add_pr});
        upd.vert = sat48(cur.vert, {16'd0, add_ve});
    end
    assign ram_wdata = upd;

    assign is_inv = qinv_reg || (qmin_reg == 32'd0) || (qmax_reg >= q_ovf_reg);

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        q_ovf_next        = cfg_we ? cfg_data : q_ovf_reg;
        vld_next          = vld_reg;
        census_next       = census_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        req_next          = req_reg;
        cls_next          = cls_reg;
        idx_next          = idx_reg;
        area_next         = area_reg;
        qmin_next         = qmin_reg;
        qmax_next         = qmax_reg;
        qinv_next         = qinv_reg;
        prim_next         = prim_reg;
        vert_next         = vert_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        bin_next          = bin_reg;
        scan_i_next       = scan_i_reg;
        scan_q_next       = scan_q_reg;
        addr_next         = addr_reg;
        qa_next           = qa_reg;
        qb_next           = qb_reg;
        dlt_next          = dlt_reg;
        mid_next          = mid_reg;
        prod_next         = prod_reg;
        part_next         = part_reg;
        sum_next          = sum_reg;
        k_next            = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = item.req_type;
                    cls_next  = item.draw_class;
                    idx_next  = item.read_index;
                    area_next = item.area[31] ? 32'd0 : $unsigned(item.area);
                    if (item.q_low > item.q_high)
                    begin
                        qmin_next = item.q_high;
                        qmax_next = item.q_low;
                    end
                    else
                    begin
                        qmin_next = item.q_low;
                        qmax_next = item.q_high;
                    end
                    qinv_next  = item.q_invalid;
                    prim_next  = item.prim_count;
                    vert_next  = item.vert_count;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (req_reg)
                    REQ_CLEAR:
                    begin
                        vld_next = '0;
                        for (int c = 0; c < CENSUS_N; c++)
                            census_next[c] = 48'd0;
                        state_next = S_IDLE;
                    end
                    REQ_READB:
                    begin
                        if (idx_reg < 7'(NBUCKET))
                        begin
                            addr_next  = idx_reg[ADDR_W-1:0];
                            state_next = S_RDOUT;
                        end
                        else
                        begin
                            result_next       = '0;
                            result_valid_next = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end
                    REQ_READC:
                    begin
                        result_next = '0;
                        if (idx_reg < CEN_TOTAL)
                        begin
                            result_next.census_count = census_reg[idx_reg[CENSUS_W-1:0]];
                            result_valid_next = 1'b1;
                            state_next        = S_IDLE;
                        end
                        else if (idx_reg == CEN_TOTAL)
                        begin
                            sum_next   = 48'd0;
                            k_next     = '0;
                            state_next = S_SUM;
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (cls_reg > CLS_LAST)
                            state_next = S_IDLE;
                        else
                        begin
                            census_next[cls_reg] = sat48(census_reg[cls_reg], 48'd1);
                            state_next = (cls_reg == CLS_DISPLACED) ? S_CHECK : S_IDLE;
                        end
                    end
                endcase
            end
            S_RDOUT:
            begin
                result_next              = '0;
                result_next.coverage_sum = cur.cov;
                result_next.moment_sum   = cur.mom;
                result_next.prim_sum     = cur.prim;
                result_next.vert_sum     = cur.vert;
                result_valid_next        = 1'b1;
                state_next               = S_IDLE;
            end
            S_SUM:
            begin
                sum_next = sat48(sum_reg, census_reg[k_reg]);
                k_next   = k_reg + 1'b1;
                if (k_reg == CENSUS_W'(CENSUS_N - 2))
                begin
                    result_next              = '0;
                    result_next.census_count = sat48(sum_reg, census_reg[k_reg]);
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            S_CHECK:
            begin
                lo_next = ({32'd0, qmin_reg} > FAR_EDGE) ? qmin_reg : FAR_EDGE[31:0];
                hi_next = ({32'd0, qmax_reg} < NEAR_EDGE) ? qmax_reg : NEAR_EDGE[31:0];
                if (is_inv)
                begin
                    addr_next  = BKT_INV;
                    phase_next = PH_INV;
                    state_next = S_RMW_RD;
                end
                else
                begin
                    if ({1'b0, qmax_reg} > {qmin_reg, 1'b0})
                        census_next[CEN_WIDE] = sat48(census_reg[CEN_WIDE], 48'd1);
                    if (qmax_reg == qmin_reg)
                    begin
                        phase_next  = PH_SINGLE;
                        scan_q_next = qmin_reg;
                        scan_i_next = '0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        phase_next = PH_FAR;
                        state_next = S_SLICE;
                    end
                end
            end
            S_SCAN:
            begin
                // Walk the edges from the near end; the first edge below q closes the bin.
                if ({32'd0, scan_q_reg} > EDGE_ROM[scan_i_reg])
                begin
                    addr_next  = (scan_i_reg == '0) ? BKT_NEAR
                                                    : ADDR_W'(scan_i_reg - 1'b1);
                    state_next = (phase_reg == PH_SINGLE) ? S_MULQ : S_RMW_RD;
                end
                else if (scan_i_reg == BIN_W'(BIN_COUNT))
                begin
                    addr_next  = BKT_FAR;
                    state_next = (phase_reg == PH_SINGLE) ? S_MULQ : S_RMW_RD;
                end
                else
                    scan_i_next = scan_i_reg + 1'b1;
            end
            S_MULQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_RMW_RD;
            end
            S_SLICE:
            begin
                if (sb > sa)
                begin
                    qa_next    = sa[31:0];
                    qb_next    = sb[31:0];
                    addr_next  = slice_addr;
                    state_next = S_PREP;
                end
                else
                    state_next = S_NEXT;
            end
            S_PREP:
            begin
                dlt_next   = qb_reg - qa_reg;
                mid_next   = 32'(({1'b0, qa_reg} + {1'b0, qb_reg}) >> 1);
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    part_next  = div_q;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_RMW_RD;
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                vld_next[addr_reg] = 1'b1;
                if (phase_reg == PH_INV || phase_reg == PH_SINGLE || phase_reg == PH_MID)
                    state_next = S_IDLE;
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                case (phase_reg)
                    PH_FAR:
                    begin
                        phase_next = PH_NEAR;
                        state_next = S_SLICE;
                    end
                    PH_NEAR:
                    begin
                        phase_next = PH_BINS;
                        bin_next   = '0;
                        state_next = S_SLICE;
                    end
                    default:
                    begin
                        if (bin_reg == BIN_W'(BIN_COUNT - 1))
                        begin
                            phase_next  = PH_MID;
                            scan_q_next = 32'(({1'b0, qmin_reg} + {1'b0, qmax_reg}) >> 1);
                            scan_i_next = '0;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            bin_next   = bin_reg + 1'b1;
                            state_next = S_SLICE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_INV;
            q_ovf_reg        <= '1;
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c < CENSUS_N; c++)
                census_reg[c] <= 48'd0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            q_ovf_reg        <= q_ovf_next;
            vld_reg          <= vld_next;
            result_valid_reg <= result_valid_next;
            census_reg       <= census_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        req_reg    <= req_next;
        cls_reg    <= cls_next;
        idx_reg    <= idx_next;
        area_reg   <= area_next;
        qmin_reg   <= qmin_next;
        qmax_reg   <= qmax_next;
        qinv_reg   <= qinv_next;
        prim_reg   <= prim_next;
        vert_reg   <= vert_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        bin_reg    <= bin_next;
        scan_i_reg <= scan_i_next;
        scan_q_reg <= scan_q_next;
        addr_reg   <= addr_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        dlt_reg    <= dlt_next;
        mid_reg    <= mid_next;
        prod_reg   <= prod_next;
        part_reg   <= part_next;
        sum_reg    <= sum_next;
        k_reg      <= k_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/ldch_check.sv =====
// Port-level assertions for the depth coverage histogram, bound to the top level.
`default_nettype none

module ldch_check (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                result_valid,
    input wire ldch_pkg::result_t   result
);

    // An accepted item raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result only follows work on an item.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in progress");

    // Each read yields a single result.
    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // A census result leaves the bucket fields at zero.
    a_census_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.census_count != 48'd0)) |->
        (result.coverage_sum == 48'd0 && result.moment_sum == 64'd0 &&
         result.prim_sum == 48'd0 && result.vert_sum == 48'd0))
        else $error("census result carries bucket data");

endmodule

bind log_depth_coverage_histogram_top ldch_check u_check (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the logarithmic depth coverage histogram.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldch_pkg::*;

    localparam int          IDLE_LIMIT = 20000;
    localparam bit [63:0]   SAT48      = 64'hFFFF_FFFF_FFFF;
    localparam bit [63:0]   FAR_Q      = 64'd4096;

    // Tracks the expected histogram contents and the reads that are still owed.
    class histogram_model;
        bit [63:0]  edge_q [0:BIN_COUNT];
        bit [63:0]  cov [NBUCKET];
        bit [63:0]  mom [NBUCKET];
        bit [63:0]  prims [NBUCKET];
        bit [63:0]  verts [NBUCKET];
        bit [63:0]  census [CENSUS_N];
        bit [63:0]  overflow_q;
        result_t    pending_reads [$];
        int         errors;
        int         reads_checked;

        function new();
            bit [63:0] roots [STEPS_PER_OCTAVE];
            bit [63:0] lo;
            bit [63:0] hi;
            bit [63:0] mid;
            int n;
            int oct;
            int rem;
            int sh;
            for (int r = 0; r < STEPS_PER_OCTAVE; r++)
            begin
                lo = 64'h8000_0000;
                hi = 64'hFFFF_FFFF;
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo + 64'd1) >> 1);
                    if (root_fits(mid, r))
                        lo = mid;
                    else
                        hi = mid - 64'd1;
                end
                roots[r] = lo;
            end
            for (int i = 0; i <= BIN_COUNT; i++)
            begin
                n = (-LOG2_W_LOW) * STEPS_PER_OCTAVE - i;
                if (n >= 0)
                    oct = n / STEPS_PER_OCTAVE;
                else
                    oct = -((-n + STEPS_PER_OCTAVE - 1) / STEPS_PER_OCTAVE);
                rem = n - oct * STEPS_PER_OCTAVE;
                sh = oct - 7;
                if (sh >= 0)
                    edge_q[i] = roots[rem] << sh;
                else if (-sh < 64)
                    edge_q[i] = roots[rem] >> (-sh);
                else
                    edge_q[i] = 64'd0;
            end
            overflow_q = 64'hFFFF_FFFF;
            wipe();
            errors = 0;
            reads_checked = 0;
        endfunction

        // The B-th power of a Q1.31 mantissa, renormalized, compared with 2^r.
        function bit root_fits(bit [63:0] m, int r);
            bit [63:0] mant;
            int ex;
            mant = 64'h8000_0000;
            ex = 0;
            for (int k = 0; k < STEPS_PER_OCTAVE; k++)
            begin
                mant = (mant * m) >> 31;
                if (mant >= 64'h1_0000_0000)
                begin
                    mant = mant >> 1;
                    ex++;
                end
            end
            return (ex < r) || ((ex == r) && (mant <= 64'h8000_0000));
        endfunction

        function void wipe();
            foreach (cov[b])
            begin
                cov[b] = 0;
                mom[b] = 0;
                prims[b] = 0;
                verts[b] = 0;
            end
            foreach (census[c])
                census[c] = 0;
        endfunction

        function bit [63:0] sat48(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s > SAT48) ? SAT48 : s;
        endfunction

        function bit [63:0] sat64(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s < a) ? '1 : s;
        endfunction

        // Returns -1 for near, a bin number, or BIN_COUNT for far.
        function int bin_at(bit [63:0] q);
            if (q > edge_q[0])
                return -1;
            for (int i = 0; i < BIN_COUNT; i++)
                if (q > edge_q[i+1])
                    return i;
            return BIN_COUNT;
        endfunction

        function int bucket_at(bit [63:0] q);
            int b;
            b = bin_at(q);
            if (b < 0)
                return BIN_COUNT;
            if (b >= BIN_COUNT)
                return BIN_COUNT + 1;
            return b;
        endfunction

        function void accumulate(int b, bit [63:0] c, bit [63:0] m, bit [63:0] p,
                                 bit [63:0] v);
            cov[b] = sat48(cov[b], c);
            mom[b] = sat64(mom[b], m);
            prims[b] = sat48(prims[b], p);
            verts[b] = sat48(verts[b], v);
        endfunction

        function void add_slice(int b, bit [63:0] area, bit [63:0] qa, bit [63:0] qb,
                                bit [63:0] dq);
            bit [63:0] part;
            if (!(qb > qa))
                return;
            part = (area * (qb - qa)) / dq;
            accumulate(b, part, part * ((qa + qb) >> 1), 0, 0);
        endfunction

        function void add_draw(req_item_t it);
            bit [63:0] area;
            bit [63:0] qmin;
            bit [63:0] qmax;
            bit [63:0] dq;
            bit [63:0] lo;
            bit [63:0] hi;
            bit [63:0] qa;
            bit [63:0] qb;
            bit [63:0] near_q;
            int first;
            int last;
            if (it.draw_class > CLS_LAST)
                return;
            census[it.draw_class] = sat48(census[it.draw_class], 1);
            if (it.draw_class != CLS_DISPLACED)
                return;
            area = it.area[31] ? 64'd0 : {32'd0, it.area};
            qmin = (it.q_low > it.q_high) ? it.q_high : it.q_low;
            qmax = (it.q_low > it.q_high) ? it.q_low : it.q_high;
            if (it.q_invalid || qmin == 0 || qmax >= overflow_q)
            begin
                accumulate(BIN_COUNT + 2, area, 0, it.prim_count, it.vert_count);
                return;
            end
            if (qmax > 2 * qmin)
                census[6] = sat48(census[6], 1);
            dq = qmax - qmin;
            if (dq == 0)
            begin
                accumulate(bucket_at(qmin), area, area * qmin, it.prim_count, it.vert_count);
                return;
            end
            near_q = edge_q[0];
            add_slice(BIN_COUNT + 1, area, qmin, (qmax < FAR_Q) ? qmax : FAR_Q, dq);
            add_slice(BIN_COUNT, area, (qmin > near_q) ? qmin : near_q, qmax, dq);
            lo = (qmin > FAR_Q) ? qmin : FAR_Q;
            hi = (qmax < near_q) ? qmax : near_q;
            if (hi > lo)
            begin
                first = bin_at(hi);
                last = bin_at(lo);
                if (first < 0)
                    first = 0;
                if (last > BIN_COUNT - 1)
                    last = BIN_COUNT - 1;
                for (int i = first; i <= last; i++)
                begin
                    qa = (edge_q[i+1] > lo) ? edge_q[i+1] : lo;
                    qb = (edge_q[i] < hi) ? edge_q[i] : hi;
                    add_slice(i, area, qa, qb, dq);
                end
            end
            accumulate(bucket_at((qmin + qmax) >> 1), 0, 0, it.prim_count, it.vert_count);
        endfunction

        function void note_item(req_item_t it);
            result_t r;
            bit [63:0] total;
            r = '0;
            case (it.req_type)
                REQ_ADD:
                    add_draw(it);
                REQ_CLEAR:
                    wipe();
                REQ_READB:
                begin
                    if (it.read_index < NBUCKET)
                    begin
                        r.coverage_sum = cov[it.read_index][47:0];
                        r.moment_sum = mom[it.read_index];
                        r.prim_sum = prims[it.read_index][47:0];
                        r.vert_sum = verts[it.read_index][47:0];
                    end
                    pending_reads = {pending_reads, r};
                end
                default:
                begin
                    if (it.read_index < CENSUS_N)
                        r.census_count = census[it.read_index][47:0];
                    else if (it.read_index == CEN_TOTAL)
                    begin
                        total = 0;
                        for (int k = 0; k < 6; k++)
                            total = sat48(total, census[k]);
                        r.census_count = total[47:0];
                    end
                    pending_reads = {pending_reads, r};
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_reads.size() == 0)
            begin
                $error("result arrived with no read outstanding");
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (got.coverage_sum !== want.coverage_sum)
            begin
                $error("coverage_sum: expected %h, got %h", want.coverage_sum, got.coverage_sum);
                errors++;
            end
            if (got.moment_sum !== want.moment_sum)
            begin
                $error("moment_sum: expected %h, got %h", want.moment_sum, got.moment_sum);
                errors++;
            end
            if (got.prim_sum !== want.prim_sum)
            begin
                $error("prim_sum: expected %h, got %h", want.prim_sum, got.prim_sum);
                errors++;
            end
            if (got.vert_sum !== want.vert_sum)
            begin
                $error("vert_sum: expected %h, got %h", want.vert_sum, got.vert_sum);
                errors++;
            end
            if (got.census_count !== want.census_count)
            begin
                $error("census_count: expected %h, got %h", want.census_count,
                       got.census_count);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_item_t  item;
    logic       cfg_we;
    logic [31:0] cfg_data;
    logic       result_valid;
    result_t    result;

    histogram_model hist;
    int         idle_cycles = 0;
    int         items_sent;
    int         draws_sent;

    log_depth_coverage_histogram_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .result_valid(result_valid),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor and watchdog: both sample on the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                hist.note_item(item);
            if (result_valid)
                hist.check_result(result);
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic issue(req_item_t it, int gap);
        start <= 1'b1;
        item <= it;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        if (it.req_type == REQ_ADD)
            draws_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (busy || hist.pending_reads.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_overflow(logic [31:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        hist.overflow_q = {32'd0, v};
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_item_t make_draw(logic [2:0] cls, logic [31:0] area,
                                            logic [31:0] qlo, logic [31:0] qhi, logic inv,
                                            logic [31:0] p, logic [31:0] v);
        req_item_t it;
        it = '0;
        it.req_type = REQ_ADD;
        it.draw_class = cls;
        it.area = area;
        it.q_low = qlo;
        it.q_high = qhi;
        it.q_invalid = inv;
        it.prim_count = p;
        it.vert_count = v;
        it.read_index = 7'($urandom);
        return it;
    endfunction

    function automatic req_item_t make_read(logic [1:0] kind, logic [6:0] idx);
        req_item_t it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(req_item_t)-1:0];
        it.req_type = kind;
        it.read_index = idx;
        return it;
    endfunction

    // q spread over many octaves so that draws land across near, bins and far.
    function automatic logic [31:0] pick_q();
        int sh;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        sh = $urandom_range(2, 22);
        return ($urandom | 32'h8000_0000) >> sh;
    endfunction

    function automatic req_item_t random_item();
        req_item_t it;
        logic [31:0] qa;
        logic [31:0] qb;
        int roll;
        int shape;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            qa = pick_q();
            shape = $urandom_range(0, 99);
            if (shape < 20)
                qb = qa;
            else if (shape < 85)
                qb = qa + (qa >> $urandom_range(1, 6));
            else if (shape < 95)
                qb = pick_q();
            else
                qb = $urandom;
            it = make_draw(($urandom_range(0, 9) < 7) ? CLS_DISPLACED : 3'($urandom),
                           ($urandom_range(0, 4) == 0) ? $urandom : $urandom >> 1,
                           $urandom_range(0, 1) ? qa : qb,
                           $urandom_range(0, 1) ? qb : qa,
                           $urandom_range(0, 19) == 0, $urandom, $urandom);
        end
        else if (roll < 78)
            it = make_read(REQ_READB, ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                                  : 7'($urandom_range(0, 66)));
        else if (roll < 98)
            it = make_read(REQ_READC, ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                                  : 7'($urandom_range(0, 7)));
        else
            it = make_read(REQ_CLEAR, 7'($urandom));
        return it;
    endfunction

    task automatic directed_items();
        issue(make_draw(CLS_DISPLACED, 32'h0100_0000, 32'h0010_0000, 32'h0010_0000, 1'b0,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, 1, 3),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, 1, 3),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h8000_0000, 32'h0000_2000, 32'h0000_1000, 1'b0, 5, 7),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h0200_0000, 32'h2000_0000, 32'h0000_0800, 1'b0, 9, 11),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h0100_0000, 32'h0, 32'h0100_0000, 1'b0, 2, 2), 0);
        issue(make_draw(CLS_DISPLACED, 32'h0100_0000, 32'h0100_0000, 32'h0200_0000, 1'b1, 4, 4),
              0);
        issue(make_draw(CLS_DISPLACED, 32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0, 6, 6),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h0040_0000, 32'h1000_0000, 32'h1000_0000, 1'b0, 1, 1),
              pick_gap());
        issue(make_draw(CLS_DISPLACED, 32'h0040_0000, 32'h0000_1000, 32'h0000_1000, 1'b0, 1, 1),
              pick_gap());
        for (int c = 1; c <= 7; c++)
            issue(make_draw(3'(c), 32'h0100_0000, 32'h0100_0000, 32'h0300_0000, 1'b0, 1, 1),
                  0);
        issue(make_read(REQ_READB, 7'(BIN_COUNT)), pick_gap());
        issue(make_read(REQ_READB, 7'(BIN_COUNT + 1)), 0);
        issue(make_read(REQ_READB, 7'(BIN_COUNT + 2)), 0);
        issue(make_read(REQ_READB, 7'd127), pick_gap());
        issue(make_read(REQ_READC, 7'd6), 0);
        issue(make_read(REQ_READC, CEN_TOTAL), 0);
        issue(make_read(REQ_READC, 7'd8), pick_gap());
        issue(make_read(REQ_CLEAR, 7'd0), 0);
        issue(make_read(REQ_READC, CEN_TOTAL), pick_gap());
    endtask

    initial
    begin
        logic [31:0] settings [5];
        hist = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        draws_sent = 0;
        settings[0] = 32'hFFFF_FFFF;
        settings[1] = 32'h0800_0000;
        settings[2] = 32'h0;
        settings[3] = $urandom;
        settings[4] = 32'hFFFF_FFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_overflow(settings[ph]);
            for (int n = 0; n < 105; n++)
                issue(random_item(), pick_gap());
        end
        settle();
        repeat (50) @(posedge clk);
        $display("Sent %0d items (%0d draws) over five q_overflow settings.",
                 items_sent, draws_sent);
        $display("Checked %0d read results against the predicted histogram.",
                 hist.reads_checked);
        if (hist.errors == 0 && hist.pending_reads.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== log_depth_coverage_histogram_top.f =====
rtl/ldch_pkg.sv
rtl/ldch_ram.sv
rtl/ldch_div.sv
rtl/log_depth_coverage_histogram_top.sv
rtl/ldch_check.sv
bench/tb.sv
